>>> hw/rtl/hdr_tone_mapper_macros.svh
// Assertion macros used by the tone mapper top level.
`ifndef HDR_TONE_MAPPER_MACROS_SVH
`define HDR_TONE_MAPPER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that, when it holds, forces a consequence in the next cycle.
`define HTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/htm_pkg.sv
// Package with the constants, codes and table functions of the tone mapper.
`default_nettype none

package htm_pkg;

   // Field widths of the fixed-point datapath.
   localparam int CFG_BITS     = 16;
   localparam int FRAC_BITS    = 16;
   localparam int MANT_BITS    = 31;
   localparam int EXPQ_BITS    = 32;
   localparam int T_BITS       = 21;
   localparam int NB_BITS      = 7;
   localparam int LOG_INT_BITS = 6;
   localparam int PROD_BITS    = 47;
   localparam int RES_BITS     = 48;
   localparam int LOG_STEPS    = 16;
   localparam int POW_STEPS    = 21;

   // Operator codes held in the mode register.
   localparam logic [1:0] MODE_SIMPLE   = 2'd0;
   localparam logic [1:0] MODE_POWER    = 2'd1;
   localparam logic [1:0] MODE_EXPOSURE = 2'd2;

   // Register indexes on the control port.
   localparam logic [1:0] REG_MAP_MODE       = 2'd0;
   localparam logic [1:0] REG_GAIN_FACTOR    = 2'd1;
   localparam logic [1:0] REG_POWER_EXPONENT = 2'd2;
   localparam logic [1:0] REG_EXPOSURE_RATE  = 2'd3;

   // Reset values of the registers.
   localparam logic [1:0]          MODE_RESET  = MODE_SIMPLE;
   localparam logic [CFG_BITS-1:0] GAIN_RESET  = 16'd256;
   localparam logic [CFG_BITS-1:0] GAMMA_RESET = 16'd29789;
   localparam logic [CFG_BITS-1:0] RATE_RESET  = 16'd256;

   // One in Q.16, and the bias of the final power shift (22 + 64).
   localparam logic [16:0]        ONE_Q16        = 17'h10000;
   localparam logic [NB_BITS-1:0] POW_SHIFT_BIAS = 7'd86;

   // Integer square root of a 64-bit value, used only to build constants.
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bitv;
      res  = '0;
      rem  = v;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bitv > rem) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // The factor 2^(2^-j) in Q2.30, found by taking the square root j times.
   function automatic logic [63:0] pow2_root(input int j);
      logic [63:0] root;
      root = 64'h8000_0000;
      for (int i = 1; i <= j; i++) begin
         root = isqrt64(root << 30);
      end
      return root;
   endfunction

   // The factor exp(-2^(k-16)) in Q.32: a truncated series below k = 16,
   // repeated squaring from k = 16 on.
   function automatic logic [63:0] exp_factor(input int k);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] e;
      int          kk;
      int          sh;
      logic        done;
      kk   = (k < 16) ? k : 15;
      sh   = 16 - kk;
      sum  = 64'h1_0000_0000;
      term = sum;
      done = 1'b0;
      for (int n = 1; n < 32; n++) begin
         if (!done) begin
            term = (term >> sh) / 64'(n);
            if (term == 0) begin
               done = 1'b1;
            end else if ((n & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      e = sum;
      for (int i = 16; i <= k; i++) begin
         e = (e * e) >> 32;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/htm_stream_if.sv
// Stream interfaces for the request and result channels of the tone mapper.
`default_nettype none

interface htm_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic                   last_in;

   modport source (output valid, output sample_in, output last_in, input ready);
   modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

interface htm_rsp_if #(parameter int SAMPLE_BITS = 24) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_out;
   logic                   last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/htm_log_cell.sv
// One cell of the front chain: a divider step and a log2 squaring step.
`default_nettype none

module htm_log_cell #(
   parameter int SAMPLE_BITS = 24,
   parameter int SIDE_BITS   = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          i_valid,
   input  logic [SAMPLE_BITS:0]          i_rem,
   input  logic [SAMPLE_BITS:0]          i_den,
   input  logic [htm_pkg::FRAC_BITS-1:0] i_quo,
   input  logic [htm_pkg::MANT_BITS-1:0] i_m,
   input  logic [htm_pkg::FRAC_BITS-1:0] i_frac,
   input  logic [SIDE_BITS-1:0]          i_side,
   output logic                          o_valid,
   output logic [SAMPLE_BITS:0]          o_rem,
   output logic [SAMPLE_BITS:0]          o_den,
   output logic [htm_pkg::FRAC_BITS-1:0] o_quo,
   output logic [htm_pkg::MANT_BITS-1:0] o_m,
   output logic [htm_pkg::FRAC_BITS-1:0] o_frac,
   output logic [SIDE_BITS-1:0]          o_side
);
   import htm_pkg::*;

   logic [SAMPLE_BITS+1:0]       shifted;
   logic [SAMPLE_BITS+1:0]       diff;
   logic                         qbit;
   logic [2*MANT_BITS-1:0]       sq;
   logic [MANT_BITS:0]           sq_hi;
   logic                         fbit;

   logic                         valid_ff;
   logic [SAMPLE_BITS:0]         rem_ff, rem_in;
   logic [SAMPLE_BITS:0]         den_ff;
   logic [FRAC_BITS-1:0]         quo_ff, quo_in;
   logic [MANT_BITS-1:0]         m_ff, m_in;
   logic [FRAC_BITS-1:0]         frac_ff, frac_in;
   logic [SIDE_BITS-1:0]         side_ff;

   // Restoring division step: shift in a zero, subtract the divisor if it fits.
   always_comb begin
      shifted = {i_rem, 1'b0};
      diff    = shifted - {1'b0, i_den};
      qbit    = (shifted >= {1'b0, i_den});
      rem_in  = qbit ? diff[SAMPLE_BITS:0] : shifted[SAMPLE_BITS:0];
      quo_in  = {i_quo[FRAC_BITS-2:0], qbit};
   end

   // Log2 step: square the mantissa and renormalize when it reaches two.
   always_comb begin
      sq      = i_m * i_m;
      sq_hi   = sq[2*MANT_BITS-1:MANT_BITS-1];
      fbit    = sq_hi[MANT_BITS];
      m_in    = fbit ? sq_hi[MANT_BITS:1] : sq_hi[MANT_BITS-1:0];
      frac_in = {i_frac[FRAC_BITS-2:0], fbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= i_den;
         quo_ff  <= quo_in;
         m_ff    <= m_in;
         frac_ff <= frac_in;
         side_ff <= i_side;
      end
   end

   assign o_valid = valid_ff;
   assign o_rem   = rem_ff;
   assign o_den   = den_ff;
   assign o_quo   = quo_ff;
   assign o_m     = m_ff;
   assign o_frac  = frac_ff;
   assign o_side  = side_ff;

endmodule

`default_nettype wire

>>> hw/rtl/htm_pow_cell.sv
// One cell of the back chain: a 2^f factor step and an exp(-t) factor step.
`default_nettype none

module htm_pow_cell #(
   parameter int STEP      = 0,
   parameter int SIDE_BITS = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          i_valid,
   input  logic [htm_pkg::MANT_BITS-1:0] i_p,
   input  logic [htm_pkg::FRAC_BITS-1:0] i_f,
   input  logic [htm_pkg::EXPQ_BITS-1:0] i_pe,
   input  logic                          i_pone,
   input  logic [htm_pkg::T_BITS-1:0]    i_t,
   input  logic [SIDE_BITS-1:0]          i_side,
   output logic                          o_valid,
   output logic [htm_pkg::MANT_BITS-1:0] o_p,
   output logic [htm_pkg::FRAC_BITS-1:0] o_f,
   output logic [htm_pkg::EXPQ_BITS-1:0] o_pe,
   output logic                          o_pone,
   output logic [htm_pkg::T_BITS-1:0]    o_t,
   output logic [SIDE_BITS-1:0]          o_side
);
   import htm_pkg::*;

   // Constant factors of this cell.
   localparam logic [MANT_BITS-1:0] ROOT = MANT_BITS'(pow2_root(STEP + 1));
   localparam logic [EXPQ_BITS-1:0] EFAC = EXPQ_BITS'(exp_factor(STEP));

   logic [2*MANT_BITS-1:0]  pm;
   logic [2*EXPQ_BITS-1:0]  em;
   logic                    fbit;
   logic                    tbit;

   logic                    valid_ff;
   logic [MANT_BITS-1:0]    p_ff, p_in;
   logic [FRAC_BITS-1:0]    f_ff, f_in;
   logic [EXPQ_BITS-1:0]    pe_ff, pe_in;
   logic                    pone_ff, pone_in;
   logic [T_BITS-1:0]       t_ff, t_in;
   logic [SIDE_BITS-1:0]    side_ff;

   // Power fraction: multiply in this root when the leading fraction bit is set.
   always_comb begin
      fbit = i_f[FRAC_BITS-1];
      pm   = i_p * ROOT;
      p_in = fbit ? pm[2*MANT_BITS-2:MANT_BITS-1] : i_p;
      f_in = {i_f[FRAC_BITS-2:0], 1'b0};
   end

   // Exponential: multiply in this factor when the lowest exposure bit is set.
   // While the product is still exactly one, the factor is taken as it is.
   always_comb begin
      tbit = i_t[0];
      em   = i_pe * EFAC;
      if (!tbit) begin
         pe_in = i_pe;
      end else if (i_pone) begin
         pe_in = EFAC;
      end else begin
         pe_in = em[2*EXPQ_BITS-1:EXPQ_BITS];
      end
      pone_in = i_pone & ~tbit;
      t_in    = {1'b0, i_t[T_BITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         f_ff    <= f_in;
         pe_ff   <= pe_in;
         pone_ff <= pone_in;
         t_ff    <= t_in;
         side_ff <= i_side;
      end
   end

   assign o_valid = valid_ff;
   assign o_p     = p_ff;
   assign o_f     = f_ff;
   assign o_pe    = pe_ff;
   assign o_pone  = pone_ff;
   assign o_t     = t_ff;
   assign o_side  = side_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hdr_tone_mapper.sv
// Top level of the tone mapper: register front end, cell chains and output buffer.
// The mapper takes one sample per clock while the output buffer has a free entry.
// The depth is set by the two cell chains: 16 cells that each do one divider step
// and one log2 squaring, then 21 cells that each multiply in one constant factor of
// 2^f and of exp(-t), with an input stage, a normalize stage, the gamma product
// stage and the final product stage around them. The whole pipeline moves as one
// and is parted from the result channel by a two-entry output buffer, so requests
// keep flowing while one result waits; the pipeline holds only once both entries
// are full. Registers are to be written only while the mapper is idle; the mapper
// does not enforce this. The stages that use them read them directly.
`default_nettype none
`include "hdr_tone_mapper_macros.svh"

module hdr_tone_mapper #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   htm_req_if.sink                      req_chan,
   htm_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [htm_pkg::CFG_BITS-1:0] csr_wdata
);
   import htm_pkg::*;

   localparam int IW     = $clog2(SAMPLE_BITS);
   localparam int L_SIDE = SAMPLE_BITS + LOG_INT_BITS + T_BITS + 3;
   localparam int P_SIDE = SAMPLE_BITS + FRAC_BITS + NB_BITS + 3;

   // Configuration registers.
   logic [1:0]          map_mode_ff;
   logic [CFG_BITS-1:0] gain_ff;
   logic [CFG_BITS-1:0] gamma_ff;
   logic [CFG_BITS-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff <= MODE_RESET;
         gain_ff     <= GAIN_RESET;
         gamma_ff    <= GAMMA_RESET;
         rate_ff     <= RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAP_MODE:       map_mode_ff <= csr_wdata[1:0];
            REG_GAIN_FACTOR:    gain_ff     <= csr_wdata;
            REG_POWER_EXPONENT: gamma_ff    <= csr_wdata;
            REG_EXPOSURE_RATE:  rate_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline advances whenever the output buffer has a free entry.
   logic adv;
   logic skid_valid_ff;

   assign adv            = ~skid_valid_ff;
   assign req_chan.ready = adv;

   // Input stage.
   logic                   s0_valid_ff;
   logic [SAMPLE_BITS-1:0] s0_x_ff;
   logic                   s0_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff    <= req_chan.sample_in;
         s0_last_ff <= req_chan.last_in;
      end
   end

   // Normalize stage: leading one, mantissa, divisor and exposure product.
   logic [IW-1:0]             lead;
   logic [LOG_INT_BITS-1:0]   boff_in;
   logic [62:0]               norm;
   logic [SAMPLE_BITS+15:0]   tprod;
   logic [SAMPLE_BITS:0]      den_in;

   always_comb begin
      lead = '0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (s0_x_ff[i]) lead = IW'(i);
      end
      boff_in = LOG_INT_BITS'(lead) - LOG_INT_BITS'(FRAC_BITS);
      norm    = (63'(s0_x_ff) << 30) >> lead;
      den_in  = {1'b0, s0_x_ff} + (SAMPLE_BITS + 1)'(ONE_Q16);
      tprod   = s0_x_ff * rate_ff;
   end

   logic                   s1_valid_ff;
   logic [SAMPLE_BITS:0]   s1_rem_ff;
   logic [SAMPLE_BITS:0]   s1_den_ff;
   logic [MANT_BITS-1:0]   s1_m_ff;
   logic [L_SIDE-1:0]      s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_rem_ff  <= {1'b0, s0_x_ff};
         s1_den_ff  <= den_in;
         s1_m_ff    <= norm[MANT_BITS-1:0];
         s1_side_ff <= {s0_last_ff, s0_x_ff, (s0_x_ff == '0), boff_in,
                        (|tprod[SAMPLE_BITS+15:T_BITS+8]), tprod[T_BITS+7:8]};
      end
   end

   // Front chain: division for the simple operator and log2 for the power one.
   logic                 l_valid [0:LOG_STEPS];
   logic [SAMPLE_BITS:0] l_rem   [0:LOG_STEPS];
   logic [SAMPLE_BITS:0] l_den   [0:LOG_STEPS];
   logic [FRAC_BITS-1:0] l_quo   [0:LOG_STEPS];
   logic [MANT_BITS-1:0] l_m     [0:LOG_STEPS];
   logic [FRAC_BITS-1:0] l_frac  [0:LOG_STEPS];
   logic [L_SIDE-1:0]    l_side  [0:LOG_STEPS];

   assign l_valid[0] = s1_valid_ff;
   assign l_rem[0]   = s1_rem_ff;
   assign l_den[0]   = s1_den_ff;
   assign l_quo[0]   = '0;
   assign l_m[0]     = s1_m_ff;
   assign l_frac[0]  = '0;
   assign l_side[0]  = s1_side_ff;

   for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
      htm_log_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .SIDE_BITS   (L_SIDE)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .i_valid (l_valid[g]),
         .i_rem   (l_rem[g]),
         .i_den   (l_den[g]),
         .i_quo   (l_quo[g]),
         .i_m     (l_m[g]),
         .i_frac  (l_frac[g]),
         .i_side  (l_side[g]),
         .o_valid (l_valid[g+1]),
         .o_rem   (l_rem[g+1]),
         .o_den   (l_den[g+1]),
         .o_quo   (l_quo[g+1]),
         .o_m     (l_m[g+1]),
         .o_frac  (l_frac[g+1]),
         .o_side  (l_side[g+1])
      );
   end

   logic                    lo_last;
   logic [SAMPLE_BITS-1:0]  lo_x;
   logic                    lo_zero;
   logic [LOG_INT_BITS-1:0] lo_boff;
   logic                    lo_tbig;
   logic [T_BITS-1:0]       lo_t;

   assign {lo_last, lo_x, lo_zero, lo_boff, lo_tbig, lo_t} = l_side[LOG_STEPS];

   // Gamma stage: gamma times log2(x), biased so the integer part is positive.
   logic signed [16:0] g_s;
   logic signed [21:0] lg_s;
   logic signed [38:0] gl_prod;
   logic [39:0]        biased;

   always_comb begin
      g_s     = {1'b0, gamma_ff};
      lg_s    = {lo_boff, l_frac[LOG_STEPS]};
      gl_prod = g_s * lg_s;
      biased  = {gl_prod[38], gl_prod} + 40'h40_0000_0000;
   end

   logic                 m_valid_ff;
   logic [FRAC_BITS-1:0] m_f_ff;
   logic [T_BITS-1:0]    m_t_ff;
   logic [P_SIDE-1:0]    m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= l_valid[LOG_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_f_ff    <= biased[31:16];
         m_t_ff    <= lo_t;
         m_side_ff <= {lo_last, lo_x, lo_zero, lo_tbig, l_quo[LOG_STEPS], biased[38:32]};
      end
   end

   // Back chain: 2^f for the power operator and exp(-t) for the exposure one.
   logic                 p_valid [0:POW_STEPS];
   logic [MANT_BITS-1:0] p_p     [0:POW_STEPS];
   logic [FRAC_BITS-1:0] p_f     [0:POW_STEPS];
   logic [EXPQ_BITS-1:0] p_pe    [0:POW_STEPS];
   logic                 p_pone  [0:POW_STEPS];
   logic [T_BITS-1:0]    p_t     [0:POW_STEPS];
   logic [P_SIDE-1:0]    p_side  [0:POW_STEPS];

   assign p_valid[0] = m_valid_ff;
   assign p_p[0]     = MANT_BITS'(1) << (MANT_BITS - 1);
   assign p_f[0]     = m_f_ff;
   assign p_pe[0]    = '0;
   assign p_pone[0]  = 1'b1;
   assign p_t[0]     = m_t_ff;
   assign p_side[0]  = m_side_ff;

   for (genvar g = 0; g < POW_STEPS; g++) begin : g_pow
      htm_pow_cell #(
         .STEP      (g),
         .SIDE_BITS (P_SIDE)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .i_valid (p_valid[g]),
         .i_p     (p_p[g]),
         .i_f     (p_f[g]),
         .i_pe    (p_pe[g]),
         .i_pone  (p_pone[g]),
         .i_t     (p_t[g]),
         .i_side  (p_side[g]),
         .o_valid (p_valid[g+1]),
         .o_p     (p_p[g+1]),
         .o_f     (p_f[g+1]),
         .o_pe    (p_pe[g+1]),
         .o_pone  (p_pone[g+1]),
         .o_t     (p_t[g+1]),
         .o_side  (p_side[g+1])
      );
   end

   // Product stage: gain times 2^f, and the rounded complement of exp(-t).
   logic [33:0] ediff;

   assign ediff = 34'h1_0000_0000 + 34'd32768 - {2'b00, p_pe[POW_STEPS]};

   logic                 f1_valid_ff;
   logic [PROD_BITS-1:0] f1_prod_ff;
   logic [16:0]          f1_er_ff;
   logic [P_SIDE-1:0]    f1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= p_valid[POW_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_prod_ff <= p_p[POW_STEPS] * gain_ff;
         f1_er_ff   <= p_pone[POW_STEPS] ? 17'd0 : ediff[32:16];
         f1_side_ff <= p_side[POW_STEPS];
      end
   end

   logic                   fo_last;
   logic [SAMPLE_BITS-1:0] fo_x;
   logic                   fo_zero;
   logic                   fo_tbig;
   logic [FRAC_BITS-1:0]   fo_quo;
   logic [NB_BITS-1:0]     fo_nb;

   assign {fo_last, fo_x, fo_zero, fo_tbig, fo_quo, fo_nb} = f1_side_ff;

   // Operator select, power scaling and saturation.
   logic [NB_BITS-1:0]     shift_amt;
   logic [RES_BITS-1:0]    pw_val;
   logic [RES_BITS-1:0]    rs_val;
   logic [SAMPLE_BITS-1:0] res_sample;

   always_comb begin
      shift_amt = POW_SHIFT_BIAS - fo_nb;
      if (fo_zero) begin
         pw_val = (gamma_ff == '0) ? RES_BITS'({gain_ff, 8'h00}) : '0;
      end else if (fo_nb > POW_SHIFT_BIAS) begin
         pw_val = '1;
      end else begin
         pw_val = {1'b0, f1_prod_ff} >> shift_amt;
      end

      case (map_mode_ff)
         MODE_SIMPLE:   rs_val = RES_BITS'(fo_quo);
         MODE_POWER:    rs_val = pw_val;
         MODE_EXPOSURE: rs_val = fo_tbig ? RES_BITS'(ONE_Q16) : RES_BITS'(f1_er_ff);
         default:       rs_val = RES_BITS'(fo_x);
      endcase

      res_sample = (|rs_val[RES_BITS-1:SAMPLE_BITS]) ? '1 : rs_val[SAMPLE_BITS-1:0];
   end

   // Two-entry output buffer: the output register and one skid entry.
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                   out_last_ff, out_last_in;
   logic                   skid_valid_in;
   logic [SAMPLE_BITS-1:0] skid_sample_ff, skid_sample_in;
   logic                   skid_last_ff, skid_last_in;
   logic                   pop;
   logic                   push;

   always_comb begin
      pop            = out_valid_ff & rsp_chan.ready;
      push           = adv & f1_valid_ff;
      out_valid_in   = out_valid_ff;
      out_sample_in  = out_sample_ff;
      out_last_in    = out_last_ff;
      skid_valid_in  = skid_valid_ff;
      skid_sample_in = skid_sample_ff;
      skid_last_in   = skid_last_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_sample_in = skid_sample_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_sample_in = res_sample;
            out_last_in   = fo_last;
         end
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_sample_in = res_sample;
         skid_last_in   = fo_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff  <= out_sample_in;
      out_last_ff    <= out_last_in;
      skid_sample_ff <= skid_sample_in;
      skid_last_ff   <= skid_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample_out = out_sample_ff;
   assign rsp_chan.last_out   = out_last_ff;

   // The skid entry only ever fills behind a waiting output register.
   `HTM_ASSERT(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid entry without output")

   // A result arriving at a stalled output must land in the skid entry.
   `HTM_ASSERT_NEXT(a_stall_to_skid,
      out_valid_ff && !rsp_chan.ready && f1_valid_ff && !skid_valid_ff,
      skid_valid_ff, "stalled result was not buffered")

   // The divider remainder is below the divisor at the end of the chain.
   `HTM_ASSERT(a_div_rem, l_valid[LOG_STEPS] |-> (l_rem[LOG_STEPS] < l_den[LOG_STEPS]),
      "divider remainder reached the divisor")

   // The 2^f product stays in [1, 2).
   `HTM_ASSERT(a_pow_range, p_valid[POW_STEPS] |-> p_p[POW_STEPS][MANT_BITS-1],
      "power fraction product left its range")

   // The exposure result never exceeds one.
   `HTM_ASSERT(a_exp_range, f1_valid_ff |-> (f1_er_ff <= ONE_Q16),
      "exposure result above one")

endmodule

`default_nettype wire
